// ===== sv/gtj_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and datapath command codes of the greedy text justifier.
package gtj_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_WORDS_DEF  = 32;
  localparam int CFG_W          = 7;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 7'd16;
  localparam logic [7:0] SPACE_CHAR = 8'd32;

  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_WEND = 2'd1;
  localparam logic [1:0] FUNC_TEND = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WCHAR,
    OP_WEND,
    OP_TEXTEND,
    OP_EMIT_INIT,
    OP_DIV_STEP,
    OP_WL_RD,
    OP_GAP_LD,
    OP_PUSH_SPACE,
    OP_LS_RD,
    OP_PUSH_CHAR,
    OP_FIN,
    OP_CP_RD,
    OP_CP_WR,
    OP_APPEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic need_flush;
    logic have_words;
    logic div_done;
    logic i_end;
    logic g_zero;
    logic last_char;
    logic line_full;
    logic can_push;
    logic cp_last;
  } dp_stat_t;

endpackage

// ===== sv/gtj_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the justifier: stores, counters, gap divider and output register.
module gtj_dp import gtj_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  in_item_t         in_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LA = $clog2(MAX_WIDTH);
  localparam int KW = $clog2(MAX_WORDS + 1);
  localparam int KA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int SW = $clog2(2 * MAX_WIDTH + MAX_WORDS + 1);
  localparam int DW = $clog2(WW + 1);

  logic [7:0]    wb_mem [MAX_WIDTH];
  logic [7:0]    ls_mem [MAX_WIDTH];
  logic [WW-1:0] wl_mem [MAX_WORDS];

  logic [CFG_W-1:0] lw_r, lw_nxt;
  logic [WW-1:0] cwl_r, cwl_nxt, len_r, len_nxt, chars_r, chars_nxt;
  logic [KW-1:0] wh_r, wh_nxt, i_r, i_nxt;
  logic [WW-1:0] ci_r, ci_nxt, n_r, n_nxt, p_r, p_nxt, j_r, j_nxt, g_r, g_nxt;
  logic [WW-1:0] q_r, q_nxt, rm_r, rm_nxt, dvd_r, dvd_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt;
  logic [WW-1:0] wl_rd_r;
  logic [7:0]    ls_rd_r, wb_rd_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic [WW-1:0] w_eff, len_c, spare;
  logic [KW-1:0] dvs;
  logic          fits, push;
  logic [WW:0]   r_sh;
  logic [WW-1:0] gap_c;

  always_comb begin
    if (lw_r == '0) begin
      w_eff = WW'(1);
    end else if (lw_r > CFG_W'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(lw_r);
    end
  end

  assign len_c = (cwl_r > w_eff) ? w_eff : cwl_r;
  assign spare = w_eff - chars_r;
  assign dvs   = wh_r - KW'(1);
  assign fits  = !cmd.last && (wh_r > KW'(1)) &&
                 (SW'(chars_r) + SW'(wh_r) - SW'(1) <= SW'(w_eff));
  assign r_sh  = {rm_r, dvd_r[WW-1]};
  assign gap_c = (i_r == '0) ? '0 :
                 q_r + (((WW+KW)'(i_r) - (WW+KW)'(1) < (WW+KW)'(rm_r)) ? WW'(1) : WW'(0));
  assign push  = (cmd.op == OP_PUSH_SPACE) || (cmd.op == OP_PUSH_CHAR);

  always_comb begin
    stat.len_zero   = (len_c == '0);
    stat.need_flush = (wh_r != '0) && ((wh_r >= KW'(MAX_WORDS)) ||
                      (SW'(chars_r) + SW'(wh_r) + SW'(len_c) > SW'(w_eff)));
    stat.have_words = (wh_r != '0);
    stat.div_done   = (dcnt_r == DW'(WW));
    stat.i_end      = (i_r == wh_r);
    stat.g_zero     = (g_r == '0);
    stat.last_char  = ((WW+1)'(j_r) + (WW+1)'(1) == (WW+1)'(wl_rd_r));
    stat.line_full  = ((WW+1)'(n_r) + (WW+1)'(1) == (WW+1)'(w_eff));
    stat.can_push   = !out_valid_r || out_ready;
    stat.cp_last    = ((WW+1)'(ci_r) + (WW+1)'(1) == (WW+1)'(len_r));
  end

  always_comb begin
    lw_nxt        = cfg_we ? cfg_wdata : lw_r;
    cwl_nxt       = cwl_r;
    len_nxt       = len_r;
    chars_nxt     = chars_r;
    wh_nxt        = wh_r;
    i_nxt         = i_r;
    ci_nxt        = ci_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    g_nxt         = g_r;
    q_nxt         = q_r;
    rm_nxt        = rm_r;
    dvd_nxt       = dvd_r;
    dcnt_nxt      = dcnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      OP_WCHAR: begin
        if (cwl_r < w_eff) cwl_nxt = cwl_r + WW'(1);
      end
      OP_WEND: begin
        len_nxt = len_c;
        ci_nxt  = '0;
      end
      OP_TEXTEND: cwl_nxt = '0;
      OP_EMIT_INIT: begin
        i_nxt   = '0;
        n_nxt   = '0;
        p_nxt   = '0;
        rm_nxt  = '0;
        dvd_nxt = spare;
        q_nxt   = fits ? WW'(0) : WW'(1);
        dcnt_nxt = fits ? DW'(0) : DW'(WW);
      end
      OP_DIV_STEP: begin
        dvd_nxt  = dvd_r << 1;
        dcnt_nxt = dcnt_r + DW'(1);
        if (r_sh >= (WW+1)'(dvs)) begin
          rm_nxt = WW'(r_sh - (WW+1)'(dvs));
          q_nxt  = {q_r[WW-2:0], 1'b1};
        end else begin
          rm_nxt = WW'(r_sh);
          q_nxt  = {q_r[WW-2:0], 1'b0};
        end
      end
      OP_GAP_LD: begin
        g_nxt = gap_c;
        j_nxt = '0;
      end
      OP_PUSH_SPACE: begin
        g_nxt = g_r - WW'(1);
      end
      OP_PUSH_CHAR: begin
        p_nxt = p_r + WW'(1);
        j_nxt = j_r + WW'(1);
        if (stat.last_char) i_nxt = i_r + KW'(1);
      end
      OP_FIN: begin
        wh_nxt    = '0;
        chars_nxt = '0;
      end
      OP_CP_WR: ci_nxt = ci_r + WW'(1);
      OP_APPEND: begin
        wh_nxt    = wh_r + KW'(1);
        chars_nxt = chars_r + len_r;
        cwl_nxt   = '0;
      end
      default: begin
      end
    endcase
    if (push) begin
      out_valid_nxt    = 1'b1;
      out_nxt.out_char = (cmd.op == OP_PUSH_CHAR) ? ls_rd_r : SPACE_CHAR;
      out_nxt.line_end = stat.line_full;
      n_nxt            = n_r + WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r        <= LINE_WIDTH_RST;
      cwl_r       <= '0;
      chars_r     <= '0;
      wh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lw_r        <= lw_nxt;
      cwl_r       <= cwl_nxt;
      chars_r     <= chars_nxt;
      wh_r        <= wh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r  <= len_nxt;
    i_r    <= i_nxt;
    ci_r   <= ci_nxt;
    n_r    <= n_nxt;
    p_r    <= p_nxt;
    j_r    <= j_nxt;
    g_r    <= g_nxt;
    q_r    <= q_nxt;
    rm_r   <= rm_nxt;
    dvd_r  <= dvd_nxt;
    dcnt_r <= dcnt_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WCHAR && cwl_r < w_eff) wb_mem[cwl_r[LA-1:0]] <= in_data.ch;
    if (cmd.op == OP_CP_RD) wb_rd_r <= wb_mem[ci_r[LA-1:0]];
    if (cmd.op == OP_CP_WR) ls_mem[LA'(chars_r + ci_r)] <= wb_rd_r;
    if (cmd.op == OP_LS_RD) ls_rd_r <= ls_mem[p_r[LA-1:0]];
    if (cmd.op == OP_APPEND) wl_mem[wh_r[KA-1:0]] <= len_r;
    if (cmd.op == OP_WL_RD) wl_rd_r <= wl_mem[i_r[KA-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_chars_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chars_r <= WW'(MAX_WIDTH))
    else $error("held characters exceed the line store");
  a_words_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wh_r <= KW'(MAX_WORDS))
    else $error("held words exceed the word slots");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> stat.can_push)
    else $error("character pushed into a full output register");

endmodule

// ===== sv/gtj_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the justifier: sequences word entry, line emission and word copy.
module gtj_ctrl import gtj_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DIV, S_WL, S_WLD, S_GAP, S_CRD, S_CPUT, S_PAD, S_FIN,
    S_CPRD, S_CPWR, S_APP
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt, cpy_r, cpy_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cpy_nxt   = cpy_r;
    cmd.op    = OP_NONE;
    cmd.last  = last_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FUNC_CHAR: cmd.op = OP_WCHAR;
            FUNC_WEND: begin
              if (!stat.len_zero) begin
                cmd.op = OP_WEND;
                if (stat.need_flush) begin
                  state_nxt = S_INIT;
                  last_nxt  = 1'b0;
                  cpy_nxt   = 1'b1;
                end else begin
                  state_nxt = S_CPRD;
                end
              end
            end
            FUNC_TEND: begin
              cmd.op = OP_TEXTEND;
              if (stat.have_words) begin
                state_nxt = S_INIT;
                last_nxt  = 1'b1;
                cpy_nxt   = 1'b0;
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_INIT: begin
        cmd.op    = OP_EMIT_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_WL;
        else cmd.op = OP_DIV_STEP;
      end
      S_WL: begin
        if (stat.i_end) begin
          state_nxt = S_PAD;
        end else begin
          cmd.op    = OP_WL_RD;
          state_nxt = S_WLD;
        end
      end
      S_WLD: begin
        cmd.op    = OP_GAP_LD;
        state_nxt = S_GAP;
      end
      S_GAP: begin
        if (stat.g_zero) begin
          state_nxt = S_CRD;
        end else if (stat.can_push) begin
          cmd.op = OP_PUSH_SPACE;
          if (stat.line_full) state_nxt = S_FIN;
        end
      end
      S_CRD: begin
        cmd.op    = OP_LS_RD;
        state_nxt = S_CPUT;
      end
      S_CPUT: begin
        if (stat.can_push) begin
          cmd.op = OP_PUSH_CHAR;
          if (stat.line_full) state_nxt = S_FIN;
          else if (stat.last_char) state_nxt = S_WL;
          else state_nxt = S_CRD;
        end
      end
      S_PAD: begin
        if (stat.can_push) begin
          cmd.op = OP_PUSH_SPACE;
          if (stat.line_full) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = cpy_r ? S_CPRD : S_IDLE;
      end
      S_CPRD: begin
        cmd.op    = OP_CP_RD;
        state_nxt = S_CPWR;
      end
      S_CPWR: begin
        cmd.op    = OP_CP_WR;
        state_nxt = stat.cp_last ? S_APP : S_CPRD;
      end
      S_APP: begin
        cmd.op    = OP_APPEND;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      cpy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      cpy_r   <= cpy_nxt;
    end
  end

endmodule

// ===== sv/greedy_full_text_justifier_top.sv =====
`timescale 1ns / 1ps
// Top level of the greedy full text justifier: controller, datapath and ports.
// An end of word with no flush copies the word into the line store; a line flush runs
// a set-up step, the gap divider (skipped for an unjustified line), then the words,
// characters and spaces of the line in order.
// Reset (rst_n, synchronous, active low) empties the held line and sets the width to 16.
module greedy_full_text_justifier_top import gtj_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gtj_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtj_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/greedy_full_text_justifier_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the greedy full text justifier: queued random and directed text, line predictor.
module greedy_full_text_justifier_top_tb;
  import gtj_pkg::*;

  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  greedy_full_text_justifier_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  in_item_t pending_requests[$];
  out_item_t expected_chars[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int watchdog = 0;
  bit timed_out = 1'b0;

  logic [7:0] held_chars[MAX_WIDTH_DEF];
  int held_lengths[MAX_WORDS_DEF];
  logic [7:0] word_chars[MAX_WIDTH_DEF];
  int held_words, held_total, word_len;
  int width_reg;

  function automatic int clamp_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  task automatic add_char(input int w, inout int n, input logic [7:0] c);
    out_item_t r;
    if (n < w) begin
      r.out_char = c;
      r.line_end = (n == w - 1);
      expected_chars.insert(expected_chars.size(), r);
      n++;
    end
  endtask

  task automatic flush_line(input bit last);
    int w, n, p, base, rem, g;
    w = clamp_width();
    n = 0;
    p = 0;
    base = 1;
    rem = 0;
    if (!last && held_words > 1 && held_total + held_words - 1 <= w) begin
      base = (w - held_total) / (held_words - 1);
      rem = (w - held_total) % (held_words - 1);
    end
    for (int i = 0; i < held_words; i++) begin
      if (i > 0) begin
        g = base + ((i - 1) < rem ? 1 : 0);
        for (int j = 0; j < g; j++) add_char(w, n, SPACE_CHAR);
      end
      for (int j = 0; j < held_lengths[i]; j++) begin
        if (p < MAX_WIDTH_DEF) add_char(w, n, held_chars[p]);
        p++;
      end
    end
    while (n < w) add_char(w, n, SPACE_CHAR);
    held_words = 0;
    held_total = 0;
  endtask

  task automatic predict_request(input in_item_t it);
    int w, len;
    w = clamp_width();
    if (it.func == FUNC_CHAR) begin
      if (word_len < w) begin
        word_chars[word_len] = it.ch;
        word_len++;
      end
    end else if (it.func == FUNC_WEND) begin
      len = word_len > w ? w : word_len;
      if (len != 0) begin
        if (held_words > 0 && (held_words >= MAX_WORDS_DEF || held_total + held_words + len > w))
          flush_line(1'b0);
        for (int i = 0; i < len; i++)
          if (held_total + i < MAX_WIDTH_DEF) held_chars[held_total + i] = word_chars[i];
        if (held_words < MAX_WORDS_DEF) begin
          held_lengths[held_words] = len;
          held_words++;
          held_total += len;
        end
        word_len = 0;
      end
    end else if (it.func == FUNC_TEND) begin
      word_len = 0;
      if (held_words > 0) flush_line(1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        void'(pending_requests.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_requests[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result char=%0d end=%0b",
                                         out_data.out_char, out_data.line_end);
        end else begin
          if (out_data !== expected_chars[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected char=%0d end=%0b, got char=%0d end=%0b",
                       expected_chars[0].out_char, expected_chars[0].line_end,
                       out_data.out_char, out_data.line_end);
          end
          void'(expected_chars.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
    end
  end

  always @(posedge clk) begin
    if (watchdog >= WD_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_word(input int len);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.func = FUNC_CHAR;
      it.ch = 8'($urandom_range(33, 126));
      pending_requests.insert(pending_requests.size(), it);
    end
    it.func = FUNC_WEND;
    it.ch = 8'($urandom);
    pending_requests.insert(pending_requests.size(), it);
  endtask

  task automatic queue_op(input logic [1:0] f, input logic [7:0] c);
    in_item_t it;
    it.func = f;
    it.ch = c;
    pending_requests.insert(pending_requests.size(), it);
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || expected_chars.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_width(input int w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(w);
    width_reg = w & 127;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random_text(input int n_items);
    int cnt, r;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(99);
      if (r < 80) begin
        r = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
        queue_word(r);
        cnt += r + 1;
      end else if (r < 88) begin
        queue_op(FUNC_TEND, 8'($urandom));
        cnt++;
      end else if (r < 94) begin
        queue_op(FUNC_WEND, 8'($urandom));
        cnt++;
      end else if (r < 97) begin
        queue_op(FUNC_CHAR, 8'($urandom));
        cnt++;
      end else begin
        queue_op(2'd3, 8'($urandom));
        cnt++;
      end
    end
    queue_op(FUNC_TEND, 8'd0);
  endtask

  initial begin
    int widths[6] = '{16, 1, 64, 127, 0, 10};
    held_words = 0;
    held_total = 0;
    word_len = 0;
    width_reg = 16;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of characters, empty word, ignored code, justification cases.
    queue_op(FUNC_CHAR, 8'h00);
    queue_op(FUNC_CHAR, 8'hFF);
    queue_op(FUNC_CHAR, 8'hAA);
    queue_op(FUNC_CHAR, 8'h55);
    queue_op(FUNC_WEND, 8'hFF);
    queue_op(FUNC_WEND, 8'h00);
    queue_op(2'd3, 8'hFF);
    queue_word(3);
    queue_word(5);
    queue_word(6);
    queue_word(20);
    queue_op(FUNC_CHAR, 8'h41);
    queue_op(FUNC_TEND, 8'hFF);
    queue_op(FUNC_TEND, 8'h00);
    drain();

    // Word slot limit at the widest line.
    set_width(64);
    for (int i = 0; i < 34; i++) queue_word(1);
    queue_op(FUNC_TEND, 8'd0);
    drain();

    // Width lowered while words are held.
    queue_word(10);
    queue_word(10);
    queue_word(10);
    drain();
    set_width(5);
    queue_op(FUNC_TEND, 8'd0);
    queue_word(4);
    drain();
    set_width(2);
    drain();
    queue_word(1);
    queue_op(FUNC_TEND, 8'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_width(widths[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 68; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 68; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      queue_random_text(30);
      drain();
    end

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/gtj_pkg.sv
sv/gtj_dp.sv
sv/gtj_ctrl.sv
sv/greedy_full_text_justifier_top.sv
bench/greedy_full_text_justifier_top_tb.sv
